@@ rtl/core/msa_pkg.sv @@
`timescale 1ns / 1ps

package msa_pkg;

  localparam int unsigned QW = 31;
  localparam int unsigned SPEED_W = 32;
  localparam int unsigned ANGLE_W = 25;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned GUARD = 28;
  localparam int unsigned CW = 64;
  localparam int unsigned ZW = 34;
  localparam int unsigned FRONT_LAT = 5;

  localparam int unsigned FRACTION_BITS_DEF = 24;
  localparam int unsigned ATAN_STEPS_DEF = 24;

  localparam logic [QW-1:0] MAXQ = '1;

  localparam logic [QW-1:0] RST_FRICTION = QW'(5033164);
  localparam logic [QW-1:0] RST_GRAVITY = QW'(164416716);
  localparam logic [QW-1:0] RST_WHEELBASE = QW'(28940697);
  localparam logic [QW-1:0] RST_HALF_TRACK = QW'(9311354);
  localparam logic [QW-1:0] RST_CG_HEIGHT = QW'(16777216);

  typedef enum logic [IDX_W-1:0] {
    REG_FRICTION   = 3'd0,
    REG_GRAVITY    = 3'd1,
    REG_WHEELBASE  = 3'd2,
    REG_HALF_TRACK = 3'd3,
    REG_CG_HEIGHT  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic ovf;
  } ctl_t;

  // Arctangent of 2^-i with 32 fraction bits.
  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
    32'd16777131, 32'd8388597, 32'd4194303, 32'd2097152,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072,
    32'd65536, 32'd32768, 32'd16384, 32'd8192,
    32'd4096, 32'd2048, 32'd1024, 32'd512,
    32'd256, 32'd128, 32'd64, 32'd32,
    32'd16, 32'd8, 32'd4, 32'd2
  };

  // Rounds a value with 32 fraction bits to f fraction bits.
  function automatic logic [ZW-1:0] to_q(input logic [ZW-1:0] v32, input int unsigned f);
    int unsigned sh;
    sh = 32 - f;
    return (v32 + (ZW'(1) << (sh - 1))) >> sh;
  endfunction

endpackage

@@ rtl/core/msa_front.sv @@
`timescale 1ns / 1ps

module msa_front import msa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SPEED_W-1:0] speed_i,
  input  logic [QW-1:0]             fc_i,
  input  logic [QW-1:0]             g_i,
  input  logic [QW-1:0]             wb_i,
  input  logic [QW-1:0]             ht_i,
  input  logic [QW-1:0]             cg_i,
  output ctl_t                      ctl_o,
  output logic [QW-1:0]             num_o,
  output logic [QW-1:0]             den_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned OS = F + QW;

  logic [FRONT_LAT-1:0] vld_q;

  logic [SPEED_W-1:0] mag_d, mag_q;
  logic [62:0]        cmpp_d, cmpp_q;

  logic        skid_d, skid2_q, skid3_q, skid4_q;
  logic [63:0] v2raw_d, v2raw_q;

  logic          ovf3_d, ovf3_q;
  logic [QW-1:0] v2_q;
  logic [61:0]   p1raw_d, p1raw_q;

  logic          ovf4_d, ovf4_q;
  logic [QW-1:0] v2b_q;
  logic [61:0]   p2raw_d, p2raw_q;
  logic [61:0]   denraw_d, denraw_q;

  logic          ovf5_d, ovf5_q;
  logic [QW-1:0] num_d, num_q;
  logic [QW-1:0] den_d, den_q;

  always_comb begin
    mag_d = speed_i[SPEED_W-1] ? (~$unsigned(speed_i) + 32'd1) : $unsigned(speed_i);
    cmpp_d = 63'({1'b0, fc_i} + 32'd1) * 63'(cg_i);
    skid_d = (fc_i != MAXQ) && ((cg_i == '0) || (cmpp_q <= (63'(ht_i) << F)));
    v2raw_d = 64'(mag_q) * 64'(mag_q);
    ovf3_d = (v2raw_q >> OS) != '0;
    p1raw_d = 62'(skid2_q ? fc_i : ht_i) * 62'(g_i);
    ovf4_d = ovf3_q || ((p1raw_q >> OS) != '0);
    p2raw_d = 62'(p1raw_q[F +: QW]) * 62'(wb_i);
    denraw_d = 62'(cg_i) * 62'(v2_q);
    ovf5_d = ovf4_q || ((p2raw_q >> OS) != '0) || (!skid4_q && ((denraw_q >> OS) != '0));
    num_d = p2raw_q[F +: QW];
    den_d = skid4_q ? v2b_q : denraw_q[F +: QW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_LAT-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    cmpp_q   <= cmpp_d;
    skid2_q  <= skid_d;
    v2raw_q  <= v2raw_d;
    skid3_q  <= skid2_q;
    ovf3_q   <= ovf3_d;
    v2_q     <= v2raw_q[F +: QW];
    p1raw_q  <= p1raw_d;
    skid4_q  <= skid3_q;
    ovf4_q   <= ovf4_d;
    v2b_q    <= v2_q;
    p2raw_q  <= p2raw_d;
    denraw_q <= denraw_d;
    ovf5_q   <= ovf5_d;
    num_q    <= num_d;
    den_q    <= den_d;
  end

  assign ctl_o = '{valid: vld_q[FRONT_LAT-1], ovf: ovf5_q};
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

@@ rtl/core/msa_div.sv @@
`timescale 1ns / 1ps

module msa_div import msa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctl_t          ctl_i,
  input  logic [QW-1:0] num_i,
  input  logic [QW-1:0] den_i,
  output ctl_t          ctl_o,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned DW = QW + F;

  logic [QW-1:0] rem_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [QW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          vld_q [QW+1];
  logic          ovf_q [QW+1];

  logic [DW-1:0] dvd;
  logic [QW:0]   hi;
  logic          ovf0;

  always_comb begin
    dvd = {num_i, {F{1'b0}}};
    hi = (QW+1)'(dvd[DW-1:QW]);
    ovf0 = ctl_i.ovf || (den_i == '0) || (hi >= {1'b0, den_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= hi[QW-1:0];
    lo_q[0]  <= dvd[QW-1:0];
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= ovf0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW:0]   t;
    logic [QW:0]   diff;
    logic          ge;
    logic [QW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      t = {rem_q[k], lo_q[k][QW-1-k]};
      diff = t - {1'b0, den_q[k]};
      ge = t >= {1'b0, den_q[k]};
      rem_d = ge ? diff[QW-1:0] : t[QW-1:0];
      quo_d = quo_q[k];
      quo_d[QW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      lo_q[k+1]  <= lo_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  assign ctl_o = '{valid: vld_q[QW], ovf: ovf_q[QW]};
  assign quo_o = quo_q[QW];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[QW] && !ovf_q[QW]) |-> (rem_q[QW] < den_q[QW]))
    else $error("Division remainder is not below the divisor.");

endmodule

@@ rtl/core/msa_cordic.sv @@
`timescale 1ns / 1ps

module msa_cordic import msa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned ATAN_STEPS = ATAN_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  logic [QW-1:0]      quo_i,
  output logic               valid_o,
  output logic [ANGLE_W-1:0] max_angle_o,
  output logic               saturated_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned N = ATAN_STEPS;
  localparam logic signed [ZW-1:0] HALF_PI = to_q(ZW'({ATAN_Q32[0], 1'b0}), F);

  logic signed [CW-1:0] x_q [N+1];
  logic signed [CW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 vld_q [N+1];
  logic                 sat_q [N+1];

  logic [QW-1:0] ratio;

  assign ratio = ctl_i.ovf ? MAXQ : quo_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CW'(1) << (F + GUARD);
    y_q[0]   <= CW'(ratio) << GUARD;
    z_q[0]   <= '0;
    sat_q[0] <= ctl_i.ovf;
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] A = to_q(ZW'(ATAN_Q32[i]), F);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!y_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + A;
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - A;
      end
      sat_q[i+1] <= sat_q[i];
    end
  end

  logic signed [ZW-1:0] zc;
  logic                 valid_q;
  logic [ANGLE_W-1:0]   angle_q;
  logic                 saturated_q;

  always_comb begin
    zc = z_q[N];
    if (zc < 0) begin
      zc = '0;
    end else if (zc > HALF_PI) begin
      zc = HALF_PI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q     <= zc[ANGLE_W-1:0];
    saturated_q <= sat_q[N];
  end

  assign valid_o     = valid_q;
  assign max_angle_o = angle_q;
  assign saturated_o = saturated_q;

  a_x_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N] |-> !x_q[N][CW-1])
    else $error("Rotation vector left the right half plane.");

endmodule

@@ rtl/core/max_steer_angle_from_speed_unit.sv @@
`timescale 1ns / 1ps

// Takes one speed item in every clock cycle; busy_o is always low. Each result
// is marked by valid_o for one cycle, and results leave in the order the items
// came in. Between start and result lie the five front-end stages, the 32
// stages of the bit-per-stage divider and the ATAN_STEPS + 2 stages of the
// arctangent rotator. The receiver cannot stall results, so it must take every
// one.
module max_steer_angle_from_speed_unit import msa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned ATAN_STEPS = ATAN_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [IDX_W-1:0]          cfg_idx_i,
  input  logic [QW-1:0]             cfg_wdata_i,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [SPEED_W-1:0] speed_i,
  output logic                      valid_o,
  output logic [ANGLE_W-1:0]        max_angle_o,
  output logic                      saturated_o
);

  localparam int unsigned LAT = FRONT_LAT + QW + 1 + ATAN_STEPS + 2;

  logic [QW-1:0] fc_q, g_q, wb_q, ht_q, cg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= RST_FRICTION;
      g_q  <= RST_GRAVITY;
      wb_q <= RST_WHEELBASE;
      ht_q <= RST_HALF_TRACK;
      cg_q <= RST_CG_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRICTION:   fc_q <= cfg_wdata_i;
        REG_GRAVITY:    g_q  <= cfg_wdata_i;
        REG_WHEELBASE:  wb_q <= cfg_wdata_i;
        REG_HALF_TRACK: ht_q <= cfg_wdata_i;
        REG_CG_HEIGHT:  cg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  ctl_t          front_ctl, div_ctl;
  logic [QW-1:0] num, den, quo;

  msa_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .speed_i(speed_i),
    .fc_i   (fc_q),
    .g_i    (g_q),
    .wb_i   (wb_q),
    .ht_i   (ht_q),
    .cg_i   (cg_q),
    .ctl_o  (front_ctl),
    .num_o  (num),
    .den_o  (den)
  );

  msa_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (front_ctl),
    .num_i (num),
    .den_i (den),
    .ctl_o (div_ctl),
    .quo_o (quo)
  );

  msa_cordic #(
    .FRACTION_BITS(FRACTION_BITS),
    .ATAN_STEPS   (ATAN_STEPS)
  ) u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .quo_i      (quo),
    .valid_o    (valid_o),
    .max_angle_o(max_angle_o),
    .saturated_o(saturated_o)
  );

  a_result_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, LAT))
    else $error("Result appeared without a matching start.");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb import msa_pkg::*;;

  localparam int unsigned FRAC = FRACTION_BITS_DEF;
  localparam int unsigned STEPS = ATAN_STEPS_DEF;
  localparam int unsigned PIPE_LAT = 39 + STEPS;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [63:0] QMAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               sat;
  } steer_res_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [IDX_W-1:0]          cfg_idx_i = '0;
  logic [QW-1:0]             cfg_wdata_i = '0;
  logic                      start_i = 1'b0;
  logic signed [SPEED_W-1:0] speed_i = '0;
  logic                      busy_o;
  logic                      valid_o;
  logic [ANGLE_W-1:0]        max_angle_o;
  logic                      saturated_o;

  logic [63:0] mu_q, grav_q, wbase_q, htrack_q, cgh_q;
  logic [SPEED_W-1:0] speed_pend_q[$];
  steer_res_t angle_exp_q[$];
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned n_items = 0;
  int unsigned n_checked = 0;
  int unsigned n_sat = 0;
  int unsigned n_bad = 0;
  int unsigned n_cycles = 0;

  max_steer_angle_from_speed_unit u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .speed_i, .valid_o, .max_angle_o, .saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b,
                                        inout bit ovf);
    logic [63:0] p;
    p = (a * b) >> FRAC;
    if (p > QMAX) begin
      ovf = 1'b1;
      return QMAX;
    end
    return p;
  endfunction

  function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b,
                                        inout bit ovf);
    logic [63:0] q;
    if (b == 0) begin
      ovf = 1'b1;
      return QMAX;
    end
    q = (a << FRAC) / b;
    if (q > QMAX) begin
      ovf = 1'b1;
      return QMAX;
    end
    return q;
  endfunction

  function automatic logic [63:0] round_q(input logic [63:0] v);
    return (v + (64'd1 << (32 - FRAC - 1))) >> (32 - FRAC);
  endfunction

  function automatic logic [63:0] ratio_atan(input logic [63:0] r);
    logic [63:0] x, y, xs, ys;
    longint z, a, half_pi;
    x = 64'd1 << (FRAC + GUARD);
    y = r << GUARD;
    z = 0;
    half_pi = longint'(round_q(64'(ATAN_Q32[0]) * 2));
    for (int i = 0; i < STEPS && i < 32; i++) begin
      xs = $signed(x) >>> i;
      ys = $signed(y) >>> i;
      a = longint'(round_q(64'(ATAN_Q32[i])));
      if (!y[63]) begin
        x += ys;
        y -= xs;
        z += a;
      end else begin
        x -= ys;
        y += xs;
        z -= a;
      end
    end
    if (z < 0) z = 0;
    if (z > half_pi) z = half_pi;
    return 64'(z);
  endfunction

  function automatic steer_res_t predict_angle(input logic [SPEED_W-1:0] s);
    logic [63:0] mag, lim, v2, prod, num, den, ratio, angle;
    bit tovf, ovf;
    steer_res_t res;
    tovf = 1'b0;
    ovf = 1'b0;
    mag = s[31] ? (64'h1_0000_0000 - 64'(s)) : 64'(s);
    lim = q_div(htrack_q, cgh_q, tovf);
    v2 = q_mul(mag, mag, ovf);
    if (mu_q < lim) begin
      prod = q_mul(mu_q, grav_q, ovf);
      num = q_mul(prod, wbase_q, ovf);
      den = v2;
    end else begin
      prod = q_mul(htrack_q, grav_q, ovf);
      num = q_mul(prod, wbase_q, ovf);
      den = q_mul(cgh_q, v2, ovf);
    end
    ratio = ovf ? QMAX : q_div(num, den, ovf);
    angle = ratio_atan(ratio);
    res.angle = angle[ANGLE_W-1:0];
    res.sat = ovf;
    return res;
  endfunction

  // Driver: records expected results for accepted items, tracks register writes and drives the pending queue in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= 64'(RST_FRICTION);
      grav_q <= 64'(RST_GRAVITY);
      wbase_q <= 64'(RST_WHEELBASE);
      htrack_q <= 64'(RST_HALF_TRACK);
      cgh_q <= 64'(RST_CG_HEIGHT);
      start_i <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FRICTION:   mu_q <= 64'(cfg_wdata_i);
          REG_GRAVITY:    grav_q <= 64'(cfg_wdata_i);
          REG_WHEELBASE:  wbase_q <= 64'(cfg_wdata_i);
          REG_HALF_TRACK: htrack_q <= 64'(cfg_wdata_i);
          REG_CG_HEIGHT:  cgh_q <= 64'(cfg_wdata_i);
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        angle_exp_q.push_back(predict_angle(speed_i));
        n_items++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (speed_pend_q.size() > 0) begin
          start_i <= 1'b1;
          speed_i <= speed_pend_q.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    steer_res_t want;
    if (rst_ni && valid_o) begin
      if (angle_exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("Unexpected result: max_angle=%0d saturated=%0b", max_angle_o, saturated_o);
        end
      end else begin
        want = angle_exp_q.pop_front();
        n_checked++;
        if (want.sat) n_sat++;
        if (want.angle !== max_angle_o || want.sat !== saturated_o) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("Mismatch: max_angle exp=%0d got=%0d, saturated exp=%0b got=%0b",
                     want.angle, max_angle_o, want.sat, saturated_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", n_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [QW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [QW-1:0] mu, input logic [QW-1:0] g,
                           input logic [QW-1:0] wb, input logic [QW-1:0] ht,
                           input logic [QW-1:0] cg);
    write_reg(REG_FRICTION, mu);
    write_reg(REG_GRAVITY, g);
    write_reg(REG_WHEELBASE, wb);
    write_reg(REG_HALF_TRACK, ht);
    write_reg(REG_CG_HEIGHT, cg);
  endtask

  task automatic drain();
    while (speed_pend_q.size() != 0 || start_i || angle_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_LAT + 10) @(posedge clk_i);
  endtask

  function automatic logic [SPEED_W-1:0] rand_speed();
    logic [SPEED_W-1:0] mag;
    case ($urandom_range(0, 5))
      0, 1: mag = $urandom_range(1 << FRAC, 60 << FRAC);
      2: mag = $urandom_range(0, 1 << FRAC);
      3: mag = $urandom_range(0, 1 << 12);
      default: mag = $urandom();
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic random_items(input int unsigned n);
    for (int i = 0; i < n; i++) speed_pend_q.push_back(rand_speed());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed speeds under the reset settings, where skidding is the limit.
    speed_pend_q = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0800, 32'h0010_0000, 32'h0100_0000, 32'hFF00_0000,
                     32'h0500_0000, 32'hFB00_0000, 32'h1E00_0000, 32'h00B5_0000,
                     32'h2D41_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    drain();

    // Tipping limit, then extremes of every register.
    write_all(31'(3 << FRAC), 31'(RST_GRAVITY), 31'(RST_WHEELBASE),
              31'(RST_HALF_TRACK), 31'(RST_CG_HEIGHT));
    speed_pend_q = '{32'h0, 32'h0100_0000, 32'hF600_0000, 32'h0003_0000, 32'h7FFF_FFFF};
    random_items(150);
    drain();

    write_all(MAXQ, MAXQ, MAXQ, MAXQ, MAXQ);
    speed_pend_q = '{32'h0, 32'h0100_0000, 32'h8000_0000};
    random_items(60);
    drain();

    write_all('0, '0, '0, '0, '0);
    speed_pend_q = '{32'h0, 32'h0100_0000, 32'hFFFF_FFFF};
    random_items(60);
    drain();

    write_all('0, 31'(RST_GRAVITY), 31'(RST_WHEELBASE), MAXQ, 31'd1);
    random_items(60);
    drain();

    // Unmapped register indexes must leave the settings alone.
    write_all(31'(RST_FRICTION), 31'(RST_GRAVITY), 31'(RST_WHEELBASE),
              31'(RST_HALF_TRACK), 31'(RST_CG_HEIGHT));
    for (int k = REG_CG_HEIGHT + 1; k < (1 << IDX_W); k++) begin
      write_reg(IDX_W'(k), QW'($urandom()));
    end
    random_items(200);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_all(QW'($urandom_range(0, 4 << FRAC)), QW'($urandom_range(1 << FRAC, 20 << FRAC)),
                QW'($urandom_range(0, 5 << FRAC)), QW'($urandom_range(0, 2 << FRAC)),
                QW'($urandom_range(1, 3 << FRAC)));
      random_items(90);
      drain();
    end

    $display("Checked %0d of %0d speed items over 11 register settings, %0d saturated.",
             n_checked, n_items, n_sat);
    $display("Settings covered skid and tip limits, zero and full-scale registers.");
    if (n_bad == 0 && angle_exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing.", n_bad, angle_exp_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
